/* rtl/nfa_lm_pkg.sv */
// Shared types and codes for the NFA longest-match block.
// No dependencies; the edge memory, the edge evaluator and the top level use this package.
package nfa_lm_pkg;

  localparam int STATE_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int KIND_W     = 2;
  localparam int OP_W       = 2;
  localparam int SLOT_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int USE_W      = 9;

  // Request operations
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  // Edge kinds; the fourth code never matches
  localparam logic [KIND_W-1:0] KIND_LITERAL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WILDCARD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EPSILON  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_STATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGES_IN_USE = 2'd2;

  typedef struct packed {
    logic [STATE_W-1:0] src;
    logic [STATE_W-1:0] dst;
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  ch;
  } edge_t;

  // Verdict of the edge evaluator for one table entry
  typedef struct packed {
    logic hit;    // edge fires and its destination is a real state
    logic fresh;  // it fires and its destination is not yet in the work set
  } eval_t;

endpackage

/* rtl/nfa_lm_req_if.sv */
// Request channel of the NFA longest-match block: valid/ready plus item fields.
// Depends on nothing.
interface nfa_lm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] edge_slot;
  logic [5:0] edge_from;
  logic [5:0] edge_to;
  logic [1:0] edge_kind;
  logic [7:0] edge_char;
  logic [7:0] symbol;

  modport source (output valid, op, edge_slot, edge_from, edge_to, edge_kind, edge_char,
                  symbol, input ready);
  modport sink   (input valid, op, edge_slot, edge_from, edge_to, edge_kind, edge_char,
                  symbol, output ready);
endinterface

/* rtl/nfa_lm_rsp_if.sv */
// Result channel of the NFA longest-match block: valid/ready plus result fields.
// Depends on nothing; LENGTH_BITS sets the length and position widths.
interface nfa_lm_rsp_if #(parameter int LENGTH_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          accepting;
  logic signed [LENGTH_BITS:0]   best_length;
  logic                          dead;
  logic        [LENGTH_BITS-1:0] position;

  modport source (output valid, accepting, best_length, dead, position, input ready);
  modport sink   (input valid, accepting, best_length, dead, position, output ready);
endinterface

/* rtl/nfa_lm_edge_mem.sv */
// Edge table storage: one write port, one read port with registered data.
// Depends on nfa_lm_pkg for the edge entry type.
module nfa_lm_edge_mem #(
  parameter int NUM_EDGES = 256
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(NUM_EDGES)-1:0] waddr,
  input  nfa_lm_pkg::edge_t            wdata,
  input  logic [$clog2(NUM_EDGES)-1:0] raddr,
  output nfa_lm_pkg::edge_t            rdata
);
  import nfa_lm_pkg::*;

  edge_t mem [NUM_EDGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/nfa_lm_edge_eval.sv */
// Shared edge evaluator: label match, source membership and destination test.
// Depends on nfa_lm_pkg for the edge entry and verdict types.
module nfa_lm_edge_eval #(
  parameter int NUM_STATES = 64
) (
  input  nfa_lm_pkg::edge_t                     entry,
  input  logic                                  closing,
  input  logic [nfa_lm_pkg::CHAR_W-1:0]         sym,
  input  logic [NUM_STATES-1:0]                 src_set,
  input  logic [NUM_STATES-1:0]                 dst_set,
  output nfa_lm_pkg::eval_t                     verdict
);
  import nfa_lm_pkg::*;

  localparam int SI = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

  function automatic logic member(input logic [NUM_STATES-1:0] s,
                                  input logic [STATE_W-1:0] i);
    member = (32'(i) < 32'(NUM_STATES)) && s[SI'(i)];
  endfunction

  logic label_ok;
  logic dst_ok;

  always_comb begin
    if (closing) begin
      label_ok = (entry.kind == KIND_EPSILON);
    end else begin
      label_ok = (entry.kind == KIND_WILDCARD) ||
                 ((entry.kind == KIND_LITERAL) && (entry.ch == sym));
    end
    dst_ok        = 32'(entry.dst) < 32'(NUM_STATES);
    verdict.hit   = label_ok && dst_ok && member(src_set, entry.src);
    verdict.fresh = verdict.hit && !member(dst_set, entry.dst);
  end

endmodule

/* rtl/nfa_longest_match.sv */
// NFA longest-match engine, top level; uses nfa_lm_pkg, both channel
// interfaces, nfa_lm_edge_mem and nfa_lm_edge_eval.
//
// Load requests write one edge (source, destination, kind, character) into the
// edge table. A begin request seeds the active set with the start state and
// closes it under epsilon edges; a step request moves the set along every
// matching edge, then closes it again. Begin and step each return one result:
// accepting, longest accepted prefix (-1 if none), dead and position. All edge
// work runs through a single edge evaluator fed by the one-read-port edge
// table, one entry per cycle. Each pass walks min(edges_in_use, NUM_EDGES)
// entries, and closure repeats passes until one adds no state; a step on a
// dead match skips the table walk. The request side is not ready while a begin
// or step is in work; a finished result sits in the output register so the
// next request can be accepted while it waits. Once a step leaves no state
// alive, the block reports dead and ignores characters until the next begin.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this.
module nfa_longest_match #(
  parameter int NUM_STATES  = 64,
  parameter int NUM_EDGES   = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [nfa_lm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfa_lm_pkg::CFG_DATA_W-1:0] cfg_data,
  nfa_lm_req_if.sink                        req,
  nfa_lm_rsp_if.source                      rsp
);
  import nfa_lm_pkg::*;

  localparam int SI = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int EA = $clog2(NUM_EDGES);
  localparam int CW = $clog2(NUM_EDGES + 1);
  localparam int NW = (CW > USE_W) ? CW : USE_W;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_CLOSE = 4'b0100,
    ST_EMIT  = 4'b1000
  } seq_t;

  function automatic logic member(input logic [NUM_STATES-1:0] s,
                                  input logic [STATE_W-1:0] i);
    member = (32'(i) < 32'(NUM_STATES)) && s[SI'(i)];
  endfunction

  // Configuration registers
  logic [STATE_W-1:0] start_state;
  logic [STATE_W-1:0] accept_state;
  logic [USE_W-1:0]   edges_in_use;

  // Match state
  logic [NUM_STATES-1:0]         active_set;
  logic [NUM_STATES-1:0]         work_set;
  logic signed [LENGTH_BITS:0]   longest_match;
  logic [LENGTH_BITS-1:0]        consumed;
  logic                          stopped;

  // Sequencer
  seq_t               st;
  logic [CW-1:0]      idx;
  logic               rd_valid;
  logic               grew;
  logic               begin_mode;
  logic [CHAR_W-1:0]  sym;

  // Datapath glue
  logic [NW-1:0]          use_ext;
  logic [CW-1:0]          limit;
  logic                   scanning;
  logic                   rd_en;
  logic                   pass_done;
  logic                   req_fire;
  logic                   load_we;
  logic                   out_free;
  logic                   acc_next;
  logic [LENGTH_BITS-1:0] consumed_next;
  edge_t                  wr_entry;
  edge_t                  rd_entry;
  eval_t                  verdict;

  // Clamp the scanned count to the table depth
  always_comb begin
    use_ext = NW'(edges_in_use);
    limit   = (use_ext > NW'(NUM_EDGES)) ? CW'(NUM_EDGES) : CW'(use_ext);
  end

  assign req.ready = (st == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign load_we   = req_fire && (req.op == OP_LOAD) &&
                     (32'(req.edge_slot) < 32'(NUM_EDGES));

  assign scanning  = (st == ST_SCAN) || (st == ST_CLOSE);
  assign rd_en     = scanning && (idx < limit);
  assign pass_done = scanning && !rd_en && !rd_valid;
  assign out_free  = !rsp.valid || rsp.ready;

  assign acc_next      = member(work_set, accept_state);
  assign consumed_next = (consumed == '1) ? consumed : consumed + 1'b1;

  always_comb begin
    wr_entry.src  = req.edge_from;
    wr_entry.dst  = req.edge_to;
    wr_entry.kind = req.edge_kind;
    wr_entry.ch   = req.edge_char;
  end

  nfa_lm_edge_mem #(
    .NUM_EDGES (NUM_EDGES)
  ) u_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (EA'(req.edge_slot)),
    .wdata (wr_entry),
    .raddr (idx[EA-1:0]),
    .rdata (rd_entry)
  );

  // Step scans read sources from the committed set; closure reads the work set
  nfa_lm_edge_eval #(
    .NUM_STATES (NUM_STATES)
  ) u_eval (
    .entry   (rd_entry),
    .closing (st == ST_CLOSE),
    .sym     (sym),
    .src_set ((st == ST_SCAN) ? active_set : work_set),
    .dst_set (work_set),
    .verdict (verdict)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_state  <= '0;
      accept_state <= '0;
      edges_in_use <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_STATE:  start_state  <= cfg_data[STATE_W-1:0];
        CFG_ACCEPT_STATE: accept_state <= cfg_data[STATE_W-1:0];
        CFG_EDGES_IN_USE: edges_in_use <= cfg_data[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and match state
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      idx           <= '0;
      rd_valid      <= 1'b0;
      grew          <= 1'b0;
      begin_mode    <= 1'b0;
      active_set    <= '0;
      longest_match <= '1;
      consumed      <= '0;
      stopped       <= 1'b0;
    end else begin
      // Walk the table: issue one read per cycle, evaluate it in the next cycle
      rd_valid <= rd_en;
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
      if (scanning && rd_valid && verdict.hit) begin
        work_set[SI'(rd_entry.dst)] <= 1'b1;
      end
      if ((st == ST_CLOSE) && rd_valid && verdict.fresh) begin
        grew <= 1'b1;
      end

      unique case (st)
        ST_IDLE: begin
          if (req_fire) begin
            idx      <= '0;
            rd_valid <= 1'b0;
            grew     <= 1'b0;
            sym      <= req.symbol;
            if (req.op == OP_BEGIN) begin
              begin_mode <= 1'b1;
              work_set   <= '0;
              if (32'(start_state) < 32'(NUM_STATES)) begin
                work_set[SI'(start_state)] <= 1'b1;
              end
              st <= ST_CLOSE;
            end else if (req.op == OP_STEP) begin
              begin_mode <= 1'b0;
              work_set   <= '0;
              // A dead match ignores characters until the next begin
              st         <= stopped ? ST_EMIT : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (pass_done) begin
            idx  <= '0;
            grew <= 1'b0;
            if (work_set == '0) begin
              stopped <= 1'b1;
              st      <= ST_EMIT;
            end else begin
              st <= ST_CLOSE;
            end
          end
        end
        ST_CLOSE: begin
          if (pass_done) begin
            idx  <= '0;
            grew <= 1'b0;
            if (!grew) begin
              // Fixed point reached: commit the set and the counters
              active_set <= work_set;
              if (begin_mode) begin
                consumed      <= '0;
                stopped       <= 1'b0;
                longest_match <= acc_next ? '0 : '1;
              end else begin
                consumed <= consumed_next;
                if (acc_next) begin
                  longest_match <= $signed({1'b0, consumed_next});
                end
              end
              st <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Result register: hold until taken, refill as the old result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((st == ST_EMIT) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st == ST_EMIT) && out_free) begin
      rsp.accepting   <= member(active_set, accept_state);
      rsp.best_length <= longest_match;
      rsp.dead        <= stopped;
      rsp.position    <= consumed;
    end
  end

`ifndef ASSERT_OFF
  // A recorded match never lies beyond the consumed position
  a_best_within_position: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.best_length[LENGTH_BITS]) |->
      (rsp.best_length[LENGTH_BITS-1:0] <= rsp.position))
    else $error("best_length exceeds position");

  // The table walk never runs past the clamped edge count
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    scanning |-> (idx <= limit))
    else $error("edge scan index beyond limit");

  // A new result appears only out of the emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    (!rsp.valid || rsp.ready) ##1 rsp.valid |-> $past(st == ST_EMIT))
    else $error("result presented outside emit step");

  // No request is taken while a table walk is in flight
  a_idle_no_walk: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rd_valid)
    else $error("request ready during edge scan");
`endif

endmodule
